/* sv/i2c_register_transfer_sequencer_core_macros.svh */
// ---------------------------------------------------------------------------
// i2c register transfer sequencer assertion macros
// concurrent checks on the rising clock edge, off while reset is asserted
// ---------------------------------------------------------------------------
`ifndef I2C_REGISTER_TRANSFER_SEQUENCER_CORE_MACROS_SVH
`define I2C_REGISTER_TRANSFER_SEQUENCER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define I2CRTS_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define I2CRTS_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define I2CRTS_ASSERT(name, clk, rst_n, prop, msg)
`define I2CRTS_ASSERT_NEVER(name, clk, rst_n, cond, msg)
`endif

`endif

/* sv/i2crts_pkg.sv */
// ---------------------------------------------------------------------------
// i2crts_pkg
// word types, opcodes, bus status codes, phases and bus commands
// ---------------------------------------------------------------------------
package i2crts_pkg;

  localparam int unsigned TX_DEPTH_DEFAULT = 16;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_EVENT = 2'd2;

  localparam logic [7:0] ST_MASK       = 8'hF8;
  localparam logic [7:0] ST_START      = 8'h08;
  localparam logic [7:0] ST_RESTART    = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
  localparam logic [7:0] ST_DATAW_ACK  = 8'h28;
  localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
  localparam logic [7:0] ST_DATAR_ACK  = 8'h50;
  localparam logic [7:0] ST_DATAR_NACK = 8'h58;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_STARTED = 3'd1;
  localparam logic [2:0] PH_ADDR    = 3'd2;
  localparam logic [2:0] PH_WRITING = 3'd3;
  localparam logic [2:0] PH_RESTART = 3'd4;
  localparam logic [2:0] PH_READING = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;
  localparam logic [2:0] PH_ERROR   = 3'd7;

  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_START  = 3'd1;
  localparam logic [2:0] CMD_GO     = 3'd2;
  localparam logic [2:0] CMD_GO_ACK = 3'd3;
  localparam logic [2:0] CMD_STOP   = 3'd4;

  typedef struct packed {
    logic [1:0] opcode;
    logic [6:0] dev_address;
    logic [7:0] register_address;
    logic [4:0] write_count;
    logic [7:0] read_count;
    logic [3:0] tx_slot;
    logic [7:0] tx_byte;
    logic [7:0] bus_status;
    logic [7:0] bus_rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] bus_command;
    logic       drive_valid;
    logic [7:0] drive_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [7:0] rx_index;
    logic       busy_res;
    logic [2:0] phase;
    logic [7:0] status_seen;
  } out_item_t;

endpackage

/* sv/i2crts_ram.sv */
// ---------------------------------------------------------------------------
// i2crts_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module i2crts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/i2crts_seq.sv */
// ---------------------------------------------------------------------------
// i2crts_seq
// transfer state, transmit store and the step logic for one word
// ---------------------------------------------------------------------------
`include "i2c_register_transfer_sequencer_core_macros.svh"

module i2crts_seq #(
  parameter int unsigned TxDepth = i2crts_pkg::TX_DEPTH_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  i2crts_pkg::in_item_t  item_i,
  output i2crts_pkg::out_item_t result_o
);
  import i2crts_pkg::*;

  localparam int unsigned AddrW = (TxDepth > 1) ? $clog2(TxDepth) : 1;
  localparam int unsigned PosW  = $clog2(TxDepth + 1);

  logic [2:0]      phase_q, phase_d;
  logic [6:0]      target_q, target_d;
  logic [7:0]      regidx_q, regidx_d;
  logic [PosW-1:0] tx_pos_q, tx_pos_d;
  logic [4:0]      tx_left_q, tx_left_d;
  logic [7:0]      rx_left_q, rx_left_d;
  logic [7:0]      rx_pos_q, rx_pos_d;
  logic            byp_q, byp_d;
  logic [7:0]      byp_data_q;

  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]       ram_rdata;
  logic [7:0]       store_byte;
  logic [7:0]       st;
  logic [7:0]       rx_left_dec;
  logic             fail;
  out_item_t        res;

  assign store_byte  = byp_q ? byp_data_q : ram_rdata;
  assign st          = item_i.bus_status & ST_MASK;
  assign rx_left_dec = (rx_left_q != 8'd0) ? rx_left_q - 8'd1 : 8'd0;
  assign wr_addr     = AddrW'(item_i.tx_slot);
  assign rd_addr     = fire_i ? tx_pos_d[AddrW-1:0] : tx_pos_q[AddrW-1:0];
  assign wr_en       = fire_i && (item_i.opcode == OP_LOAD) &&
                       (32'(item_i.tx_slot) < TxDepth);
  assign byp_d       = wr_en && (wr_addr == rd_addr);

  always_comb begin
    phase_d   = phase_q;
    target_d  = target_q;
    regidx_d  = regidx_q;
    tx_pos_d  = tx_pos_q;
    tx_left_d = tx_left_q;
    rx_left_d = rx_left_q;
    rx_pos_d  = rx_pos_q;
    res       = '0;
    fail      = 1'b0;
    case (item_i.opcode)
      OP_START: begin
        target_d  = item_i.dev_address;
        regidx_d  = item_i.register_address;
        tx_left_d = (32'(item_i.write_count) > TxDepth) ? 5'(TxDepth) : item_i.write_count;
        tx_pos_d  = '0;
        rx_left_d = item_i.read_count;
        rx_pos_d  = 8'd0;
        phase_d   = PH_STARTED;
        res.bus_command = CMD_START;
      end
      OP_EVENT: begin
        res.status_seen = st;
        case (phase_q)
          PH_STARTED: begin
            if (st == ST_START || st == ST_RESTART) begin
              res.drive_valid = 1'b1;
              res.drive_byte  = {target_q, 1'b0};
              res.bus_command = CMD_GO;
              phase_d         = PH_ADDR;
            end else begin
              fail = 1'b1;
            end
          end
          PH_ADDR: begin
            if (st == ST_SLAW_ACK) begin
              res.drive_valid = 1'b1;
              res.drive_byte  = regidx_q;
              res.bus_command = CMD_GO;
              phase_d = (tx_left_q == 5'd0 && rx_left_q != 8'd0) ? PH_RESTART : PH_WRITING;
            end else begin
              fail = 1'b1;
            end
          end
          PH_WRITING: begin
            if (st == ST_DATAW_ACK) begin
              if (tx_left_q != 5'd0) begin
                res.drive_valid = 1'b1;
                res.drive_byte  = store_byte;
                res.bus_command = CMD_GO;
                tx_pos_d        = tx_pos_q + PosW'(1);
                tx_left_d       = tx_left_q - 5'd1;
              end else if (rx_left_q != 8'd0) begin
                res.bus_command = CMD_START;
                phase_d         = PH_RESTART;
              end else begin
                res.bus_command = CMD_STOP;
                phase_d         = PH_DONE;
              end
            end else begin
              fail = 1'b1;
            end
          end
          PH_RESTART: begin
            if (st == ST_DATAW_ACK) begin
              res.bus_command = CMD_START;
            end else if (st == ST_START || st == ST_RESTART) begin
              res.drive_valid = 1'b1;
              res.drive_byte  = {target_q, 1'b1};
              res.bus_command = CMD_GO;
              phase_d         = PH_READING;
            end else begin
              fail = 1'b1;
            end
          end
          PH_READING: begin
            if (st == ST_SLAR_ACK) begin
              res.bus_command = (rx_left_q > 8'd1) ? CMD_GO_ACK : CMD_GO;
            end else if (st == ST_DATAR_ACK) begin
              res.rx_valid    = 1'b1;
              res.rx_byte     = item_i.bus_rx_byte;
              res.rx_index    = rx_pos_q;
              rx_pos_d        = rx_pos_q + 8'd1;
              rx_left_d       = rx_left_dec;
              res.bus_command = (rx_left_dec > 8'd1) ? CMD_GO_ACK : CMD_GO;
            end else if (st == ST_DATAR_NACK) begin
              res.rx_valid    = 1'b1;
              res.rx_byte     = item_i.bus_rx_byte;
              res.rx_index    = rx_pos_q;
              res.bus_command = CMD_STOP;
              phase_d         = PH_DONE;
            end else begin
              fail = 1'b1;
            end
          end
          default: begin
            fail = 1'b1;
          end
        endcase
        if (fail) begin
          res.bus_command = CMD_STOP;
          res.drive_valid = 1'b0;
          res.drive_byte  = 8'd0;
          res.rx_valid    = 1'b0;
          res.rx_byte     = 8'd0;
          res.rx_index    = 8'd0;
          phase_d         = PH_ERROR;
        end
      end
      default: begin
        res.bus_command = CMD_NONE;
      end
    endcase
    res.phase    = phase_d;
    res.busy_res = (phase_d != PH_IDLE) && (phase_d != PH_DONE) && (phase_d != PH_ERROR);
  end

  assign result_o = res;

  i2crts_ram #(
    .Width (8),
    .Depth (TxDepth)
  ) u_tx_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (item_i.tx_byte),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      target_q  <= '0;
      regidx_q  <= '0;
      tx_pos_q  <= '0;
      tx_left_q <= '0;
      rx_left_q <= '0;
      rx_pos_q  <= '0;
      byp_q     <= 1'b0;
    end else begin
      byp_q <= byp_d;
      if (fire_i) begin
        phase_q   <= phase_d;
        target_q  <= target_d;
        regidx_q  <= regidx_d;
        tx_pos_q  <= tx_pos_d;
        tx_left_q <= tx_left_d;
        rx_left_q <= rx_left_d;
        rx_pos_q  <= rx_pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= item_i.tx_byte;
  end

  // bytes still to send plus bytes already sent never exceed the store
  `I2CRTS_ASSERT(a_tx_span, clk_i, rst_ni, (32'(tx_left_q) + 32'(tx_pos_q) <= TxDepth), "tx span beyond store")

endmodule

/* sv/i2c_register_transfer_sequencer_core.sv */
// ---------------------------------------------------------------------------
// i2c_register_transfer_sequencer_core
// i2c master register transfer sequencer: one command word per input word
// ---------------------------------------------------------------------------
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-----------
//   in      | input     | in_valid_i / in_stall_o  | in_data_i
//   out     | output    | out_valid_o / out_stall_i| out_data_o
//
// one word per cycle sustained while out_stall_i is low, each word passing through
// input register, single step logic, result register
// transmit store read is registered, a load to the slot under read is bypassed
// reset clears control state only, store contents are undefined until loaded
// in_stall_o rises only while a result waits and out_stall_i is high
// ---------------------------------------------------------------------------
`include "i2c_register_transfer_sequencer_core_macros.svh"

module i2c_register_transfer_sequencer_core #(
  parameter int unsigned TxDepth = i2crts_pkg::TX_DEPTH_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  i2crts_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output i2crts_pkg::out_item_t out_data_o
);
  import i2crts_pkg::*;

  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t result;
  logic      adv;
  logic      fire;
  logic      take;

  assign adv        = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && adv;
  assign in_stall_o = s1_valid_q && !adv;
  assign take       = in_valid_i && !in_stall_o;

  i2crts_seq #(
    .TxDepth (TxDepth)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (s1_item_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!s1_valid_q || adv) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_item_q <= in_data_i;
    end
    if (fire) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  `I2CRTS_ASSERT(a_fire_shows, clk_i, rst_ni, fire |=> out_valid_o, "processed word not presented")
  `I2CRTS_ASSERT(a_stall_cause, clk_i, rst_ni, in_stall_o |-> (out_valid_o && out_stall_i), "input stalled without output backpressure")
  `I2CRTS_ASSERT_NEVER(a_drive_rx, clk_i, rst_ni, out_valid_o && out_data_o.drive_valid && out_data_o.rx_valid, "drive and receive in one word")
  `I2CRTS_ASSERT(a_busy_phase, clk_i, rst_ni, (out_valid_o && (out_data_o.phase == PH_IDLE || out_data_o.phase == PH_DONE || out_data_o.phase == PH_ERROR)) |-> !out_data_o.busy_res, "busy in a resting phase")

endmodule
